// ===== src/mit_pkg.sv =====
// Shared types and constants for the multiplexed interval timer bank.
// Holds the item and result layouts and the command and status bundles
// that join the controller and the datapath. Depends on nothing.
`default_nettype none

package mit_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int TIME_W        = 32;
  localparam int SLOT_OUT_W    = 4;
  localparam int TAG_W         = 16;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_DEL_ONE = 2'd2;
  localparam logic [1:0] OP_DEL_ALL = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_IVAL = 2'd1;
  localparam logic [1:0] ST_NO_SLOT   = 2'd2;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [30:0]      interval_ms;
    logic             periodic;
    logic [TAG_W-1:0] tag;
    logic [3:0]       slot_sel;
  } mit_item_t;

  typedef struct packed {
    logic                  kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [TAG_W-1:0]      fired_tag;
    logic [1:0]            status;
    logic                  last;
  } mit_result_t;

  typedef struct packed {
    logic capture;
    logic tick_start;
    logic add_exec;
    logic delete;
    logic scan_clear;
    logic scan_run;
    logic decide;
    logic div_step;
    logic wake_write;
    logic flush;
  } mit_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       out_free;
    logic       pend_valid;
    logic       scan_done;
    logic       found;
    logic       periodic;
    logic       div_done;
    logic       n_full;
  } mit_status_t;

endpackage

`default_nettype wire

// ===== src/mit_datapath.sv =====
// Datapath of the timer bank: time base, armed bits, slot memories, slot scan,
// remainder divider, pending fire result and output register.
// Depends on mit_pkg.
`default_nettype none

module mit_datapath #(
  parameter int SLOTS = mit_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  mit_pkg::mit_item_t  item,
  input  mit_pkg::mit_cmd_t   cmd,
  output mit_pkg::mit_status_t status,
  output logic                result_valid,
  input  logic                result_ready,
  output mit_pkg::mit_result_t result
);
  import mit_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam int DW = $clog2(TIME_W + 1);

  mit_item_t item_q;

  logic [TIME_W-1:0] now;
  logic [SLOTS-1:0]  armed;

  logic [TIME_W-1:0] wake_mem [SLOTS];
  logic [TIME_W-1:0] per_mem  [SLOTS];
  logic [TAG_W-1:0]  tag_mem  [SLOTS];

  logic [CW-1:0]     cnt;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     rd_idx;
  logic              rd_valid;
  logic [TIME_W-1:0] rd_wake;
  logic [TIME_W-1:0] rd_per;
  logic [TAG_W-1:0]  rd_tag;
  logic [TIME_W-1:0] rd_diff;
  logic [TIME_W-1:0] rd_late;
  logic              rd_expired;
  logic              rd_better;

  logic              best_found;
  logic [IW-1:0]     best_idx;
  logic [TIME_W-1:0] best_late;
  logic [TIME_W-1:0] best_per;
  logic [TAG_W-1:0]  best_tag;

  logic              free_any;
  logic [IW-1:0]     free_idx;
  logic              add_ok;

  logic              wake_we;
  logic [IW-1:0]     wake_waddr;
  logic [TIME_W-1:0] wake_wdata;

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvd;
  logic [DW-1:0]     dcnt;
  logic [TIME_W-1:0] div_shift;
  logic              div_done;
  logic              div_active;
  logic [TIME_W-1:0] new_wake;

  logic              pend_valid;
  logic [IW-1:0]     pend_slot;
  logic [TAG_W-1:0]  pend_tag;
  logic [NW-1:0]     n;

  logic              out_free;
  logic              out_load;
  mit_result_t       out_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
  end

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!armed[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign add_ok = cmd.add_exec && (item_q.interval_ms != '0) && free_any;

  assign wake_we    = add_ok || cmd.wake_write;
  assign wake_waddr = cmd.wake_write ? best_idx : free_idx;
  assign wake_wdata = cmd.wake_write ? new_wake : now + TIME_W'(item_q.interval_ms);

  assign rd_addr = cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (wake_we) begin
      wake_mem[wake_waddr] <= wake_wdata;
    end
    if (add_ok) begin
      per_mem[free_idx] <= item_q.periodic ? TIME_W'(item_q.interval_ms) : '0;
      tag_mem[free_idx] <= item_q.tag;
    end
    rd_wake <= wake_mem[rd_addr];
    rd_per  <= per_mem[rd_addr];
    rd_tag  <= tag_mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  // A wakeup at or before the current time counts as expired, using the signed difference.
  assign rd_diff    = rd_wake - now;
  assign rd_late    = now - rd_wake;
  assign rd_expired = (rd_diff == '0) || rd_diff[TIME_W-1];
  assign rd_better  = rd_valid && armed[rd_idx] && rd_expired &&
                      (!best_found || (rd_late > best_late));

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clear) begin
      cnt        <= '0;
      rd_valid   <= 1'b0;
      best_found <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_run && (cnt != CW'(SLOTS));
      if (cmd.scan_run && (cnt != CW'(SLOTS))) begin
        cnt <= cnt + 1'b1;
      end
      if (rd_better) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_better) begin
      best_idx  <= rd_idx;
      best_late <= rd_late;
      best_per  <= rd_per;
      best_tag  <= rd_tag;
    end
  end

  // The next wakeup is the current time minus the lateness remainder plus one period.
  assign div_shift  = {rem[TIME_W-2:0], dvd[TIME_W-1]};
  assign div_done   = (dcnt == DW'(TIME_W));
  assign div_active = cmd.div_step && !div_done;
  assign new_wake   = now - rem + best_per;

  always_ff @(posedge clk) begin
    if (rst || cmd.decide) begin
      dcnt <= '0;
    end else if (div_active) begin
      dcnt <= dcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      rem <= '0;
      dvd <= best_late;
    end else if (div_active) begin
      rem <= (div_shift >= best_per) ? div_shift - best_per : div_shift;
      dvd <= {dvd[TIME_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now        <= '0;
      armed      <= '0;
      pend_valid <= 1'b0;
      n          <= '0;
    end else begin
      if (cmd.tick_start) begin
        now        <= now + 1'b1;
        n          <= '0;
        pend_valid <= 1'b0;
      end
      if (add_ok) begin
        armed[free_idx] <= 1'b1;
      end
      if (cmd.delete) begin
        if (item_q.opcode == OP_DEL_ALL) begin
          armed <= '0;
        end else if (int'(item_q.slot_sel) < SLOTS) begin
          armed[IW'(item_q.slot_sel)] <= 1'b0;
        end
      end
      if (cmd.decide) begin
        if (best_found) begin
          pend_valid <= 1'b1;
          n          <= n + 1'b1;
          if (best_per == '0) begin
            armed[best_idx] <= 1'b0;
          end
        end else begin
          pend_valid <= 1'b0;
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && best_found) begin
      pend_slot <= best_idx;
      pend_tag  <= best_tag;
    end
  end

  assign out_free = !result_valid || result_ready;

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (cmd.add_exec) begin
      out_load      = 1'b1;
      out_next.kind = KIND_ACK;
      out_next.last = 1'b1;
      if (item_q.interval_ms == '0) begin
        out_next.status = ST_ZERO_IVAL;
      end else if (!free_any) begin
        out_next.status = ST_NO_SLOT;
      end else begin
        out_next.status = ST_OK;
        out_next.slot   = SLOT_OUT_W'(free_idx);
      end
    end else if ((cmd.decide && pend_valid) || cmd.flush) begin
      out_load           = 1'b1;
      out_next.kind      = KIND_FIRE;
      out_next.slot      = SLOT_OUT_W'(pend_slot);
      out_next.fired_tag = pend_tag;
      out_next.status    = ST_OK;
      out_next.last      = cmd.flush || !best_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= out_next;
    end
  end

  assign status.opcode     = item_q.opcode;
  assign status.out_free   = out_free;
  assign status.pend_valid = pend_valid;
  assign status.scan_done  = (cnt == CW'(SLOTS)) && !rd_valid;
  assign status.found      = best_found;
  assign status.periodic   = (best_per != '0);
  assign status.div_done   = div_done;
  assign status.n_full     = (n == NW'(MAX_RESULTS));

  assert property (@(posedge clk) disable iff (rst) n <= NW'(MAX_RESULTS))
    else $error("More timers fired in one tick than the result cap allows.");

  assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("Output register loaded while an earlier item still waits.");

  assert property (@(posedge clk) disable iff (rst) add_ok |=> armed[$past(free_idx)])
    else $error("Accepted timer did not arm its slot.");

  assert property (@(posedge clk) disable iff (rst)
                   (cmd.scan_run && best_found) |-> armed[best_idx])
    else $error("Scan picked a slot that is not armed.");

  assert property (@(posedge clk) disable iff (rst) cmd.wake_write |-> (rem < best_per))
    else $error("Lateness remainder is not below the period.");

endmodule

`default_nettype wire

// ===== src/mit_controller.sv =====
// Sequencing state machine of the timer bank: decodes each item and drives
// the datapath through scan, fire, remainder and result steps.
// Depends on mit_pkg.
`default_nettype none

module mit_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  mit_pkg::mit_status_t status,
  output mit_pkg::mit_cmd_t    cmd
);
  import mit_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_DECODE    = 10'b0000000010,
    S_ADD       = 10'b0000000100,
    S_SCAN_INIT = 10'b0000001000,
    S_SCAN      = 10'b0000010000,
    S_DECIDE    = 10'b0000100000,
    S_DIV       = 10'b0001000000,
    S_WRITE     = 10'b0010000000,
    S_AFTER     = 10'b0100000000,
    S_FLUSH     = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.opcode)
          OP_TICK: begin
            cmd.tick_start = 1'b1;
            state_next     = S_SCAN_INIT;
          end
          OP_ADD: begin
            state_next = S_ADD;
          end
          OP_DEL_ONE, OP_DEL_ALL: begin
            cmd.delete = 1'b1;
            state_next = S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_ADD: begin
        if (status.out_free) begin
          cmd.add_exec = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN_INIT: begin
        cmd.scan_clear = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.decide = 1'b1;
          if (!status.found) begin
            state_next = S_IDLE;
          end else if (status.periodic) begin
            state_next = S_DIV;
          end else begin
            state_next = S_AFTER;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wake_write = 1'b1;
        state_next     = S_AFTER;
      end
      S_AFTER: begin
        state_next = status.n_full ? S_FLUSH : S_SCAN_INIT;
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/multiplexed_interval_timers.sv =====
// An add is answered with a result after its item is accepted.
// A tick runs the one-slot-per-cycle scan once, and again after each timer that fires;
// each periodic firing also runs the 32-step remainder divider.
// One item is in work at a time; the next is taken once the last result is in the output register.
// Synchronous reset clears the time base, all armed bits and the control state; no clearing pass.
// Depends on mit_pkg, mit_controller and mit_datapath.
`default_nettype none

module multiplexed_interval_timers #(
  parameter int SLOTS = mit_pkg::SLOTS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  mit_pkg::mit_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output mit_pkg::mit_result_t result
);
  import mit_pkg::*;

  mit_cmd_t    cmd;
  mit_status_t status;

  mit_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  mit_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
